@@ sv/jts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package jts_pkg;

    localparam int QDEPTH = 4;

    // Token kinds
    localparam logic [3:0] KIND_LBRACE   = 4'd0;
    localparam logic [3:0] KIND_RBRACE   = 4'd1;
    localparam logic [3:0] KIND_LBRACKET = 4'd2;
    localparam logic [3:0] KIND_RBRACKET = 4'd3;
    localparam logic [3:0] KIND_COLON    = 4'd4;
    localparam logic [3:0] KIND_COMMA    = 4'd5;
    localparam logic [3:0] KIND_STRING   = 4'd6;
    localparam logic [3:0] KIND_NUMBER   = 4'd7;
    localparam logic [3:0] KIND_FALSE    = 4'd8;
    localparam logic [3:0] KIND_TRUE     = 4'd9;
    localparam logic [3:0] KIND_NULL     = 4'd10;

    // Error codes
    localparam logic [2:0] ERR_BAD_CHAR    = 3'd0;
    localparam logic [2:0] ERR_BAD_DOT_EXP = 3'd1;
    localparam logic [2:0] ERR_BAD_MINUS   = 3'd2;
    localparam logic [2:0] ERR_BAD_PLUS    = 3'd3;
    localparam logic [2:0] ERR_BAD_NUM_END = 3'd4;
    localparam logic [2:0] ERR_BAD_IDENT   = 3'd5;

    // Characters
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;

    typedef enum logic [6:0] {
        MODE_IDLE  = 7'b0000001,
        MODE_STR   = 7'b0000010,
        MODE_ESC   = 7'b0000100,
        MODE_NUM   = 7'b0001000,
        MODE_ALPHA = 7'b0010000,
        MODE_MINUS = 7'b0100000,
        MODE_ERR   = 7'b1000000
    } scan_mode_t;

    typedef struct packed {
        scan_mode_t  mode;
        logic        seen_dot;
        logic        saw_exp;
        logic [7:0]  prev_byte;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [2:0]  run_len;
        logic [2:0]  cand;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        mode:        MODE_IDLE,
        seen_dot:    1'b0,
        saw_exp:     1'b0,
        prev_byte:   8'h00,
        first_byte:  8'h00,
        second_byte: 8'h00,
        run_len:     3'd0,
        cand:        3'b111
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       doc_last;
    } byte_item_t;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] value_byte;
        logic       has_byte;
        logic       token_end;
        logic       is_error;
        logic [2:0] error_code;
        logic       doc_end;
        logic       run_last;
    } token_item_t;

    typedef struct packed {
        token_item_t [2:0] item;
        logic [1:0]        count;
    } token_list_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_e(input logic [7:0] b);
        return (b == 8'h65) || (b == 8'h45);
    endfunction

    function automatic token_item_t mk_item(input logic [3:0] kind, input logic [7:0] vb,
                                            input logic hb, input logic te,
                                            input logic er, input logic [2:0] code);
        token_item_t r;
        r.token_kind = kind;
        r.value_byte = vb;
        r.has_byte   = hb;
        r.token_end  = te;
        r.is_error   = er;
        r.error_code = code;
        r.doc_end    = 1'b0;
        r.run_last   = 1'b0;
        return r;
    endfunction

    // Appends one result; a step never produces more than three.
    function automatic token_list_t push(input token_list_t l, input token_item_t r);
        token_list_t o;
        o = l;
        if (l.count != 2'd3)
        begin
            o.item[l.count] = r;
            o.count = l.count + 2'd1;
        end
        return o;
    endfunction

    // Literal texts: 0 false, 1 true, 2 null.
    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            2'd0:
            begin
                case (idx)
                    3'd0: c = 8'h66;
                    3'd1: c = 8'h61;
                    3'd2: c = 8'h6C;
                    3'd3: c = 8'h73;
                    3'd4: c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (idx)
                    3'd0: c = 8'h74;
                    3'd1: c = 8'h72;
                    3'd2: c = 8'h75;
                    3'd3: c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            2'd2:
            begin
                case (idx)
                    3'd0: c = 8'h6E;
                    3'd1: c = 8'h75;
                    3'd2: c = 8'h6C;
                    3'd3: c = 8'h6C;
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] k);
        return (k == 2'd0) ? 3'd5 : 3'd4;
    endfunction

endpackage

`default_nettype wire

@@ sv/jts_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface jts_stream_if #(
    parameter type item_t = logic [7:0]
);
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ sv/jts_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jts_step (
    input  jts_pkg::scan_state_t state,
    input  logic [7:0]           data_byte,
    input  logic                 doc_last,
    output jts_pkg::scan_state_t next_state,
    output jts_pkg::token_list_t results
);
    import jts_pkg::*;

    typedef struct packed {
        scan_state_t st;
        token_list_t res;
    } step_ctx_t;

    function automatic step_ctx_t fail(input step_ctx_t c, input logic [2:0] code);
        step_ctx_t o;
        o = c;
        o.res = push(o.res, mk_item(KIND_LBRACE, 8'h00, 1'b0, 1'b0, 1'b1, code));
        o.st.mode = MODE_ERR;
        return o;
    endfunction

    function automatic step_ctx_t num_append(input step_ctx_t c, input logic [7:0] b);
        step_ctx_t o;
        o = c;
        if (c.st.run_len == 3'd0)
        begin
            o.st.first_byte = b;
        end
        else if (c.st.run_len == 3'd1)
        begin
            o.st.second_byte = b;
        end
        if (c.st.run_len != 3'd7)
        begin
            o.st.run_len = c.st.run_len + 3'd1;
        end
        o.st.prev_byte = b;
        o.res = push(o.res, mk_item(KIND_NUMBER, b, 1'b1, 1'b0, 1'b0, ERR_BAD_CHAR));
        return o;
    endfunction

    function automatic step_ctx_t num_start(input step_ctx_t c, input logic [7:0] b);
        step_ctx_t o;
        o = c;
        o.st.seen_dot = 1'b0;
        o.st.saw_exp  = 1'b0;
        o.st.run_len  = 3'd0;
        o.st.mode     = MODE_NUM;
        return num_append(o, b);
    endfunction

    function automatic step_ctx_t num_byte(input step_ctx_t c, input logic [7:0] b);
        step_ctx_t o;
        o = c;
        if (b == CH_DOT)
        begin
            if (c.st.seen_dot || c.st.saw_exp)
            begin
                o = fail(c, ERR_BAD_DOT_EXP);
            end
            else
            begin
                o.st.seen_dot = 1'b1;
                o = num_append(o, b);
            end
        end
        else if (b == CH_MINUS)
        begin
            o = is_e(c.st.prev_byte) ? num_append(c, b) : fail(c, ERR_BAD_MINUS);
        end
        else if (is_e(b))
        begin
            if (c.st.saw_exp)
            begin
                o = fail(c, ERR_BAD_DOT_EXP);
            end
            else
            begin
                o.st.saw_exp = 1'b1;
                o = num_append(o, b);
            end
        end
        else if (b == CH_PLUS)
        begin
            o = is_e(c.st.prev_byte) ? num_append(c, b) : fail(c, ERR_BAD_PLUS);
        end
        else
        begin
            o = num_append(c, b);
        end
        return o;
    endfunction

    // Leaves the mode at idle on success and at error otherwise.
    function automatic step_ctx_t num_finish(input step_ctx_t c);
        step_ctx_t o;
        o = c;
        if ((c.st.prev_byte == CH_DOT) || is_e(c.st.prev_byte) ||
            ((c.st.first_byte == CH_ZERO) && (c.st.run_len > 3'd2) &&
             (c.st.second_byte != CH_DOT)))
        begin
            o = fail(c, ERR_BAD_NUM_END);
        end
        else
        begin
            o.res = push(o.res, mk_item(KIND_NUMBER, 8'h00, 1'b0, 1'b1, 1'b0, ERR_BAD_CHAR));
            o.st.mode = MODE_IDLE;
        end
        return o;
    endfunction

    function automatic step_ctx_t alpha_byte(input step_ctx_t c, input logic [7:0] b);
        step_ctx_t o;
        o = c;
        for (int k = 0; k < 3; k++)
        begin
            if ((c.st.run_len >= lit_len(2'(k))) || (lit_char(2'(k), c.st.run_len) != b))
            begin
                o.st.cand[k] = 1'b0;
            end
        end
        if (c.st.run_len != 3'd7)
        begin
            o.st.run_len = c.st.run_len + 3'd1;
        end
        return o;
    endfunction

    function automatic step_ctx_t alpha_finish(input step_ctx_t c);
        step_ctx_t o;
        logic      hit;
        o = c;
        hit = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (!hit && c.st.cand[k] && (c.st.run_len == lit_len(2'(k))))
            begin
                hit = 1'b1;
                o.res = push(o.res, mk_item(KIND_FALSE + 4'(k), 8'h00, 1'b0, 1'b1, 1'b0,
                                            ERR_BAD_CHAR));
                o.st.mode = MODE_IDLE;
            end
        end
        if (!hit)
        begin
            o = fail(c, ERR_BAD_IDENT);
        end
        return o;
    endfunction

    function automatic step_ctx_t mark(input step_ctx_t c, input logic [3:0] kind,
                                       input logic [7:0] b);
        step_ctx_t o;
        o = c;
        o.res = push(o.res, mk_item(kind, b, 1'b1, 1'b1, 1'b0, ERR_BAD_CHAR));
        return o;
    endfunction

    function automatic step_ctx_t dispatch(input step_ctx_t c, input logic [7:0] b);
        step_ctx_t o;
        o = c;
        if (b == CH_LBRACE)
        begin
            o = mark(c, KIND_LBRACE, b);
        end
        else if (b == CH_RBRACE)
        begin
            o = mark(c, KIND_RBRACE, b);
        end
        else if (b == CH_LBRACKET)
        begin
            o = mark(c, KIND_LBRACKET, b);
        end
        else if (b == CH_RBRACKET)
        begin
            o = mark(c, KIND_RBRACKET, b);
        end
        else if (b == CH_COLON)
        begin
            o = mark(c, KIND_COLON, b);
        end
        else if (b == CH_COMMA)
        begin
            o = mark(c, KIND_COMMA, b);
        end
        else if (b == CH_QUOTE)
        begin
            o.st.mode = MODE_STR;
        end
        else if (b == CH_MINUS)
        begin
            o.st.mode = MODE_MINUS;
        end
        else if ((b == CH_SPACE) || (b == CH_LF) || (b == CH_CR))
        begin
            o = c;
        end
        else if (is_digit(b))
        begin
            o = num_start(c, b);
        end
        else if (is_letter(b))
        begin
            o.st.mode    = MODE_ALPHA;
            o.st.run_len = 3'd0;
            o.st.cand    = 3'b111;
            o = alpha_byte(o, b);
        end
        else
        begin
            o = fail(c, ERR_BAD_CHAR);
        end
        return o;
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h74:   r = 8'h09;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            default: r = b;
        endcase
        return r;
    endfunction

    step_ctx_t ctx;
    logic      redispatch;

    always_comb
    begin
        ctx.st     = state;
        ctx.res    = '0;
        redispatch = 1'b0;

        unique case (state.mode)
            MODE_STR:
            begin
                if (data_byte == CH_QUOTE)
                begin
                    ctx.res = push(ctx.res, mk_item(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0,
                                                    ERR_BAD_CHAR));
                    ctx.st.mode = MODE_IDLE;
                end
                else if (data_byte == CH_BSLASH)
                begin
                    ctx.st.mode = MODE_ESC;
                end
                else
                begin
                    ctx.res = push(ctx.res, mk_item(KIND_STRING, data_byte, 1'b1, 1'b0, 1'b0,
                                                    ERR_BAD_CHAR));
                end
            end
            MODE_ESC:
            begin
                ctx.res = push(ctx.res, mk_item(KIND_STRING, unescape(data_byte), 1'b1, 1'b0,
                                                1'b0, ERR_BAD_CHAR));
                ctx.st.mode = MODE_STR;
            end
            MODE_MINUS:
            begin
                if (is_digit(data_byte))
                begin
                    ctx = num_start(ctx, CH_MINUS);
                    ctx = num_append(ctx, data_byte);
                end
                else
                begin
                    ctx = fail(ctx, ERR_BAD_CHAR);
                end
            end
            MODE_NUM:
            begin
                if (is_digit(data_byte) || (data_byte == CH_DOT) || (data_byte == CH_MINUS) ||
                    (data_byte == CH_PLUS) || is_e(data_byte))
                begin
                    ctx = num_byte(ctx, data_byte);
                end
                else
                begin
                    ctx = num_finish(ctx);
                    redispatch = (ctx.st.mode == MODE_IDLE);
                end
            end
            MODE_ALPHA:
            begin
                if (is_letter(data_byte))
                begin
                    ctx = alpha_byte(ctx, data_byte);
                end
                else
                begin
                    ctx = alpha_finish(ctx);
                    redispatch = (ctx.st.mode == MODE_IDLE);
                end
            end
            MODE_IDLE:
            begin
                redispatch = 1'b1;
            end
            default:
            begin
                ctx.st = state;
            end
        endcase

        // A token that ends on this byte lets the byte start the next one.
        if (redispatch)
        begin
            ctx = dispatch(ctx, data_byte);
        end

        if (doc_last)
        begin
            case (ctx.st.mode)
                MODE_STR:
                begin
                    ctx.res = push(ctx.res, mk_item(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0,
                                                    ERR_BAD_CHAR));
                end
                MODE_ESC:
                begin
                    ctx.res = push(ctx.res, mk_item(KIND_STRING, CH_BSLASH, 1'b1, 1'b0, 1'b0,
                                                    ERR_BAD_CHAR));
                    ctx.res = push(ctx.res, mk_item(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0,
                                                    ERR_BAD_CHAR));
                end
                MODE_NUM:   ctx = num_finish(ctx);
                MODE_ALPHA: ctx = alpha_finish(ctx);
                MODE_MINUS: ctx = fail(ctx, ERR_BAD_CHAR);
                default:    ctx.res = ctx.res;
            endcase
            // A document end with nothing else to report still gets one marker result.
            if (ctx.res.count == 2'd0)
            begin
                ctx.res = push(ctx.res, mk_item(KIND_LBRACE, 8'h00, 1'b0, 1'b0, 1'b0,
                                                ERR_BAD_CHAR));
            end
            ctx.res.item[ctx.res.count - 2'd1].doc_end = 1'b1;
            ctx.st = SCAN_RESET;
        end

        if (ctx.res.count != 2'd0)
        begin
            ctx.res.item[ctx.res.count - 2'd1].run_last = 1'b1;
        end
    end

    assign next_state = ctx.st;
    assign results    = ctx.res;

endmodule

`default_nettype wire

@@ sv/json_token_scanner_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Streaming JSON lexer. byte_stream carries one document byte and a doc_last
// flag per transfer; token_stream carries one token result per transfer.
// A byte is registered at its transfer and decoded once the queue has room;
// its zero to three results are pushed into a four-entry result queue whose
// head drives token_stream, so the first result of a byte is offered from
// the queue register after the byte has been decoded.
// Throughput is one byte per cycle as long as each byte gives at most one
// result and the receiver keeps ready high. A byte that gives two or three
// results occupies the output for one transfer per result; the decoder
// waits until the queue has room for three results, which the queue
// occupancy sets.
// When the receiver stalls, results stay in the queue, the decoder and the
// input register fill, and byte_stream ready falls; nothing is lost.
// The final result of each document carries doc_end, after which the scan
// state returns to its reset value for the next document.
// An asynchronous reset empties the input register and the queue and puts
// the scanner in its idle state outside any token.
module json_token_scanner_unit (
    input  logic         clk,
    input  logic         rst_n,
    jts_stream_if.sink   byte_stream,
    jts_stream_if.source token_stream
);
    import jts_pkg::*;

    logic          in_valid_reg;
    logic          in_valid_next;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;
    scan_state_t   state_reg;
    scan_state_t   step_state;
    token_list_t   step_results;
    token_item_t   q_reg [QDEPTH];
    token_item_t   q_next [QDEPTH];
    token_item_t   q_base [QDEPTH];
    logic [2:0]    q_count_reg;
    logic [2:0]    q_count_next;
    logic [2:0]    base_count;
    logic [2:0]    slot;
    logic          pop;
    logic          fire;
    logic          accept;
    logic          step_error;

    jts_step u_step (
        .state      (state_reg),
        .data_byte  (in_byte_reg),
        .doc_last   (in_last_reg),
        .next_state (step_state),
        .results    (step_results)
    );

    assign pop        = (q_count_reg != 3'd0) && token_stream.ready;
    assign base_count = q_count_reg - {2'b00, pop};
    // The decoder moves on only when the queue can take a full set of results.
    assign fire       = in_valid_reg && (base_count <= 3'd1);
    assign accept     = byte_stream.valid && byte_stream.ready;

    assign byte_stream.ready    = !in_valid_reg || fire;
    assign token_stream.valid   = (q_count_reg != 3'd0);
    assign token_stream.payload = q_reg[0];

    assign in_valid_next = accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    always_comb
    begin
        step_error = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            if ((2'(j) < step_results.count) && step_results.item[j].is_error)
            begin
                step_error = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (pop && (i < QDEPTH - 1))
            begin
                q_base[i] = q_reg[i + 1];
            end
            else
            begin
                q_base[i] = q_reg[i];
            end
        end
        for (int i = 0; i < QDEPTH; i++)
        begin
            slot      = 3'(i) - base_count;
            q_next[i] = q_base[i];
            if (fire && (3'(i) >= base_count) && (slot < {1'b0, step_results.count}))
            begin
                q_next[i] = step_results.item[slot[1:0]];
            end
        end
        q_count_next = base_count + (fire ? {1'b0, step_results.count} : 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= SCAN_RESET;
            q_count_reg  <= 3'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            q_count_reg  <= q_count_next;
            if (fire)
            begin
                state_reg <= step_state;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= byte_stream.payload.data_byte;
            in_last_reg <= byte_stream.payload.doc_last;
        end
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count_reg <= 3'(QDEPTH))
        else $error("result queue holds more entries than it has");

    a_doc_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        token_stream.valid && token_stream.payload.doc_end |-> token_stream.payload.run_last)
        else $error("document end result is not the last of its byte");

    a_reset_after_doc: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_last_reg |=> state_reg == SCAN_RESET)
        else $error("scan state not cleared after the last byte of a document");

    a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        fire && step_error && !in_last_reg |=> state_reg.mode == MODE_ERR)
        else $error("scan error did not enter the error mode");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

    import jts_pkg::*;

    localparam int RANDOM_BYTES = 245;
    localparam logic [3:0] NO_KIND = 4'd0;
    localparam logic [2:0] NO_CODE = 3'd0;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        bit          typed;
        token_item_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    jts_stream_if #(.item_t(byte_item_t))  byte_stream ();
    jts_stream_if #(.item_t(token_item_t)) token_stream ();

    json_token_scanner_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (byte_stream),
        .token_stream (token_stream)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Scanner state as the testbench sees it.
    scan_mode_t  tok_mode;
    logic        dot_seen;
    logic        exp_seen;
    logic [7:0]  num_prev;
    logic [7:0]  num_first;
    logic [7:0]  num_second;
    logic [2:0]  run_len;
    logic [2:0]  lit_cand;

    token_item_t step_res [3];
    int          step_cnt;

    token_item_t expected_tokens [$];
    stim_row_t   directed_rows [$];
    logic [7:0]  doc_bytes [$];
    int          mismatches;
    int          bytes_sent;
    int          tokens_seen;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch: %s", what);
    endtask

    task automatic field_check(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      tokens_seen, name, got, want));
    endtask

    function automatic logic digit_byte(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic letter_byte(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic exp_mark(input logic [7:0] b);
        return b == "e" || b == "E";
    endfunction

    function automatic int literal_len(input int k);
        return (k == 0) ? 5 : 4;
    endfunction

    function automatic void scanner_reset();
        tok_mode   = MODE_IDLE;
        dot_seen   = 1'b0;
        exp_seen   = 1'b0;
        num_prev   = 8'h00;
        num_first  = 8'h00;
        num_second = 8'h00;
        run_len    = 3'd0;
        lit_cand   = 3'b111;
    endfunction

    function automatic void emit_token(input logic [3:0] kind, input logic [7:0] vb,
                                       input logic hb, input logic te,
                                       input logic er, input logic [2:0] code);
        if (step_cnt < 3)
        begin
            step_res[step_cnt] = token_item_t'{kind, vb, hb, te, er, code, 1'b0, 1'b0};
            step_cnt++;
        end
    endfunction

    function automatic void raise_error(input logic [2:0] code);
        emit_token(NO_KIND, 8'h00, 1'b0, 1'b0, 1'b1, code);
        tok_mode = MODE_ERR;
    endfunction

    function automatic void number_append(input logic [7:0] b);
        if (run_len == 3'd0)
            num_first = b;
        else if (run_len == 3'd1)
            num_second = b;
        if (run_len < 3'd7)
            run_len = run_len + 3'd1;
        num_prev = b;
        emit_token(KIND_NUMBER, b, 1'b1, 1'b0, 1'b0, NO_CODE);
    endfunction

    function automatic void number_start(input logic [7:0] b);
        dot_seen = 1'b0;
        exp_seen = 1'b0;
        run_len  = 3'd0;
        tok_mode = MODE_NUM;
        number_append(b);
    endfunction

    // A zero may lead a number of three or more bytes only in front of a dot.
    function automatic logic number_close();
        if (num_prev == CH_DOT || exp_mark(num_prev) ||
            (num_first == CH_ZERO && run_len > 3'd2 && num_second != CH_DOT))
        begin
            raise_error(ERR_BAD_NUM_END);
            return 1'b0;
        end
        emit_token(KIND_NUMBER, 8'h00, 1'b0, 1'b1, 1'b0, NO_CODE);
        tok_mode = MODE_IDLE;
        return 1'b1;
    endfunction

    function automatic void alpha_take(input logic [7:0] b);
        logic [39:0] txt;
        for (int k = 0; k < 3; k++)
        begin
            txt = (k == 0) ? "false" : (k == 1) ? "true" : "null";
            if (run_len >= literal_len(k))
                lit_cand[k] = 1'b0;
            else if (txt[8 * (literal_len(k) - 1 - run_len) +: 8] != b)
                lit_cand[k] = 1'b0;
        end
        if (run_len < 3'd7)
            run_len = run_len + 3'd1;
    endfunction

    function automatic logic alpha_close();
        for (int k = 0; k < 3; k++)
        begin
            if (lit_cand[k] && run_len == literal_len(k))
            begin
                emit_token(KIND_FALSE + 4'(k), 8'h00, 1'b0, 1'b1, 1'b0, NO_CODE);
                tok_mode = MODE_IDLE;
                return 1'b1;
            end
        end
        raise_error(ERR_BAD_IDENT);
        return 1'b0;
    endfunction

    function automatic void idle_byte(input logic [7:0] b);
        case (b)
            CH_LBRACE:   emit_token(KIND_LBRACE, b, 1'b1, 1'b1, 1'b0, NO_CODE);
            CH_RBRACE:   emit_token(KIND_RBRACE, b, 1'b1, 1'b1, 1'b0, NO_CODE);
            CH_LBRACKET: emit_token(KIND_LBRACKET, b, 1'b1, 1'b1, 1'b0, NO_CODE);
            CH_RBRACKET: emit_token(KIND_RBRACKET, b, 1'b1, 1'b1, 1'b0, NO_CODE);
            CH_COLON:    emit_token(KIND_COLON, b, 1'b1, 1'b1, 1'b0, NO_CODE);
            CH_COMMA:    emit_token(KIND_COMMA, b, 1'b1, 1'b1, 1'b0, NO_CODE);
            CH_QUOTE:    tok_mode = MODE_STR;
            CH_MINUS:    tok_mode = MODE_MINUS;
            CH_SPACE, CH_LF, CH_CR:
            begin
            end
            default:
            begin
                if (digit_byte(b))
                    number_start(b);
                else if (letter_byte(b))
                begin
                    tok_mode = MODE_ALPHA;
                    run_len  = 3'd0;
                    lit_cand = 3'b111;
                    alpha_take(b);
                end
                else
                    raise_error(ERR_BAD_CHAR);
            end
        endcase
    endfunction

    // Works out the results of one accepted byte into step_res.
    function automatic void predict_tokens(input logic [7:0] b, input logic last);
        logic       ok;
        logic [7:0] plain;
        step_cnt = 0;
        case (tok_mode)
            MODE_STR:
            begin
                if (b == CH_QUOTE)
                begin
                    emit_token(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0, NO_CODE);
                    tok_mode = MODE_IDLE;
                end
                else if (b == CH_BSLASH)
                    tok_mode = MODE_ESC;
                else
                    emit_token(KIND_STRING, b, 1'b1, 1'b0, 1'b0, NO_CODE);
            end
            MODE_ESC:
            begin
                case (b)
                    "t":     plain = 8'h09;
                    "n":     plain = CH_LF;
                    "r":     plain = CH_CR;
                    "b":     plain = 8'h08;
                    "f":     plain = 8'h0C;
                    default: plain = b;
                endcase
                emit_token(KIND_STRING, plain, 1'b1, 1'b0, 1'b0, NO_CODE);
                tok_mode = MODE_STR;
            end
            MODE_MINUS:
            begin
                if (digit_byte(b))
                begin
                    number_start(CH_MINUS);
                    number_append(b);
                end
                else
                    raise_error(ERR_BAD_CHAR);
            end
            MODE_NUM:
            begin
                if (digit_byte(b) || b == CH_DOT || b == CH_MINUS || b == CH_PLUS || exp_mark(b))
                begin
                    ok = 1'b1;
                    if (b == CH_DOT)
                    begin
                        if (dot_seen || exp_seen)
                        begin
                            raise_error(ERR_BAD_DOT_EXP);
                            ok = 1'b0;
                        end
                        else
                            dot_seen = 1'b1;
                    end
                    else if (b == CH_MINUS)
                    begin
                        if (!exp_mark(num_prev))
                        begin
                            raise_error(ERR_BAD_MINUS);
                            ok = 1'b0;
                        end
                    end
                    else if (exp_mark(b))
                    begin
                        if (exp_seen)
                        begin
                            raise_error(ERR_BAD_DOT_EXP);
                            ok = 1'b0;
                        end
                        else
                            exp_seen = 1'b1;
                    end
                    else if (b == CH_PLUS)
                    begin
                        if (!exp_mark(num_prev))
                        begin
                            raise_error(ERR_BAD_PLUS);
                            ok = 1'b0;
                        end
                    end
                    if (ok)
                        number_append(b);
                end
                else if (number_close())
                    idle_byte(b);
            end
            MODE_ALPHA:
            begin
                if (letter_byte(b))
                    alpha_take(b);
                else if (alpha_close())
                    idle_byte(b);
            end
            MODE_IDLE:
                idle_byte(b);
            default:
            begin
            end
        endcase

        if (last)
        begin
            // Whatever token is still open gets closed by the end of the document.
            case (tok_mode)
                MODE_STR:
                    emit_token(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0, NO_CODE);
                MODE_ESC:
                begin
                    emit_token(KIND_STRING, CH_BSLASH, 1'b1, 1'b0, 1'b0, NO_CODE);
                    emit_token(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0, NO_CODE);
                end
                MODE_NUM:
                    void'(number_close());
                MODE_ALPHA:
                    void'(alpha_close());
                MODE_MINUS:
                    raise_error(ERR_BAD_CHAR);
                default:
                begin
                end
            endcase
            if (step_cnt == 0)
                emit_token(NO_KIND, 8'h00, 1'b0, 1'b0, 1'b0, NO_CODE);
            step_res[step_cnt - 1].doc_end = 1'b1;
            scanner_reset();
        end

        if (step_cnt > 0)
            step_res[step_cnt - 1].run_last = 1'b1;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic last,
                                    input bit typed = 1'b0, input token_item_t want = '0);
        stim_row_t r;
        r.data  = b;
        r.last  = last;
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            doc_bytes.push_back(s[i]);
    endfunction

    function automatic void push_digits(input int n);
        repeat (n)
            doc_bytes.push_back(8'("0" + $urandom_range(0, 9)));
    endfunction

    function automatic void push_separator();
        string seps;
        seps = " ,]}\n";
        doc_bytes.push_back(seps[$urandom_range(0, 4)]);
    endfunction

    function automatic int next_gap();
        return ((bytes_sent % 64) < 16) ? 0 : $urandom_range(0, 10);
    endfunction

    // Offers one byte, waits for its transfer and queues what it should produce.
    task automatic send_byte(input logic [7:0] b, input logic last, input int gap,
                             input bit typed, input token_item_t want);
        if (gap > 0)
        begin
            byte_stream.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_stream.valid             <= 1'b1;
        byte_stream.payload.data_byte <= b;
        byte_stream.payload.doc_last  <= last;
        do
            @(posedge clk);
        while (!byte_stream.ready);
        predict_tokens(b, last);
        if (typed)
            expected_tokens.push_back(want);
        else
            for (int i = 0; i < step_cnt; i++)
                expected_tokens.push_back(step_res[i]);
        bytes_sent++;
    endtask

    // Result side: random stalls, two long hold-offs to back up the block.
    initial
    begin
        token_item_t got;
        token_item_t want;
        int          stall;
        token_stream.ready <= 1'b0;
        tokens_seen = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (tokens_seen == 40 || tokens_seen == 220)
                stall = 80;
            else
                stall = ((tokens_seen % 50) < 12) ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                token_stream.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            token_stream.ready <= 1'b1;
            do
                @(posedge clk);
            while (!token_stream.valid);
            got = token_stream.payload;
            if (expected_tokens.size() == 0)
                report_mismatch($sformatf("result %0d arrived with none expected", tokens_seen));
            else
            begin
                want = expected_tokens.pop_front();
                field_check("token_kind", got.token_kind, want.token_kind);
                field_check("value_byte", got.value_byte, want.value_byte);
                field_check("has_byte", got.has_byte, want.has_byte);
                field_check("token_end", got.token_end, want.token_end);
                field_check("is_error", got.is_error, want.is_error);
                field_check("error_code", got.error_code, want.error_code);
                field_check("doc_end", got.doc_end, want.doc_end);
                field_check("run_last", got.run_last, want.run_last);
            end
            tokens_seen++;
        end
    end

    initial
    begin
        int         n;
        int         wait_cycles;
        logic [7:0] c;
        string      marks;
        string      blanks;
        string      escapes;
        marks   = "{}[]:,";
        blanks  = " \n\r";
        escapes = "tnrbf\\\"/";
        mismatches = 0;
        bytes_sent = 0;
        scanner_reset();
        rst_n                         <= 1'b0;
        byte_stream.valid             <= 1'b0;
        byte_stream.payload.data_byte <= 8'h00;
        byte_stream.payload.doc_last  <= 1'b0;

        // Braced document: an escape, extreme bytes, a signed fraction with exponent, null.
        add_row(CH_LBRACE, 1'b0, 1'b1,
                token_item_t'{KIND_LBRACE, CH_LBRACE, 1'b1, 1'b1, 1'b0, NO_CODE, 1'b0, 1'b1});
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_BSLASH, 1'b0);
        add_row("n", 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_COLON, 1'b0, 1'b1,
                token_item_t'{KIND_COLON, CH_COLON, 1'b1, 1'b1, 1'b0, NO_CODE, 1'b0, 1'b1});
        add_row(CH_MINUS, 1'b0);
        add_row(CH_ZERO, 1'b0);
        add_row(CH_DOT, 1'b0);
        add_row("e", 1'b0);
        add_row(CH_PLUS, 1'b0);
        add_row("9", 1'b0);
        add_row(CH_RBRACKET, 1'b0);
        push_text("null");
        while (doc_bytes.size() != 0)
            add_row(doc_bytes.pop_front(), 1'b0);
        add_row(CH_RBRACE, 1'b1);
        // Leading zero on a long number, then bytes ignored up to the end.
        add_row(CH_ZERO, 1'b0);
        add_row("1", 1'b0);
        add_row("2", 1'b0);
        add_row(CH_SPACE, 1'b0, 1'b1,
                token_item_t'{NO_KIND, 8'h00, 1'b0, 1'b0, 1'b1, ERR_BAD_NUM_END, 1'b0, 1'b1});
        add_row("x", 1'b1, 1'b1,
                token_item_t'{NO_KIND, 8'h00, 1'b0, 1'b0, 1'b0, NO_CODE, 1'b1, 1'b1});
        // Stray character, then a document ending on whitespace.
        add_row("#", 1'b0, 1'b1,
                token_item_t'{NO_KIND, 8'h00, 1'b0, 1'b0, 1'b1, ERR_BAD_CHAR, 1'b0, 1'b1});
        add_row(CH_SPACE, 1'b1, 1'b1,
                token_item_t'{NO_KIND, 8'h00, 1'b0, 1'b0, 1'b0, NO_CODE, 1'b1, 1'b1});
        // String left open on a backslash.
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_BSLASH, 1'b1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].last, next_gap(),
                      directed_rows[i].typed, directed_rows[i].want);

        // Random documents: mostly well-formed tokens, now and then a broken one.
        while (bytes_sent < directed_rows.size() + RANDOM_BYTES)
        begin
            doc_bytes.delete();
            repeat ($urandom_range(2, 9))
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4:
                        doc_bytes.push_back(marks[$urandom_range(0, 5)]);
                    5, 6, 7, 8:
                    begin
                        doc_bytes.push_back(CH_QUOTE);
                        n = $urandom_range(0, 5);
                        repeat (n)
                        begin
                            if ($urandom_range(0, 3) == 0)
                            begin
                                doc_bytes.push_back(CH_BSLASH);
                                if ($urandom_range(0, 3) == 0)
                                    doc_bytes.push_back(8'($urandom_range(0, 255)));
                                else
                                    doc_bytes.push_back(escapes[$urandom_range(0, 7)]);
                            end
                            else
                            begin
                                c = 8'($urandom_range(0, 255));
                                if (c == CH_QUOTE || c == CH_BSLASH)
                                    c = "a";
                                doc_bytes.push_back(c);
                            end
                        end
                        doc_bytes.push_back(CH_QUOTE);
                    end
                    9, 10, 11, 12:
                    begin
                        if ($urandom_range(0, 2) == 0)
                            doc_bytes.push_back(CH_MINUS);
                        c = 8'("0" + $urandom_range(0, 9));
                        doc_bytes.push_back(c);
                        if (c != CH_ZERO)
                            push_digits($urandom_range(0, 3));
                        if ($urandom_range(0, 1) == 1)
                        begin
                            doc_bytes.push_back(CH_DOT);
                            push_digits($urandom_range(1, 3));
                        end
                        if ($urandom_range(0, 2) == 0)
                        begin
                            doc_bytes.push_back(($urandom_range(0, 1) == 1) ? "e" : "E");
                            case ($urandom_range(0, 2))
                                1:       doc_bytes.push_back(CH_PLUS);
                                2:       doc_bytes.push_back(CH_MINUS);
                                default: ;
                            endcase
                            push_digits($urandom_range(1, 2));
                        end
                        push_separator();
                    end
                    13, 14, 15:
                    begin
                        case ($urandom_range(0, 2))
                            0:       push_text("false");
                            1:       push_text("true");
                            default: push_text("null");
                        endcase
                        push_separator();
                    end
                    16, 17:
                        doc_bytes.push_back(blanks[$urandom_range(0, 2)]);
                    default:
                    begin
                        case ($urandom_range(0, 7))
                            0:  doc_bytes.push_back(8'($urandom_range(0, 255)));
                            1:  push_text("1.2.3");
                            2:  push_text("4e5E6");
                            3:  push_text("12-3");
                            4:  push_text("3+1");
                            5:
                            begin
                                case ($urandom_range(0, 2))
                                    0:       push_text("012");
                                    1:       push_text("7.");
                                    default: push_text("8e");
                                endcase
                                push_separator();
                            end
                            6:
                            begin
                                repeat ($urandom_range(1, 6))
                                    doc_bytes.push_back(8'((($urandom_range(0, 1) == 1) ? "A" : "a")
                                                           + $urandom_range(0, 25)));
                                push_separator();
                            end
                            default:
                            begin
                                doc_bytes.push_back(CH_MINUS);
                                c = 8'($urandom_range(0, 255));
                                if (digit_byte(c))
                                    c = "x";
                                doc_bytes.push_back(c);
                            end
                        endcase
                    end
                endcase
            end
            // Some documents are cut short so that they may end inside a token.
            if ($urandom_range(0, 4) == 0 && doc_bytes.size() > 1)
                repeat ($urandom_range(1, doc_bytes.size() - 1))
                    void'(doc_bytes.pop_back());
            foreach (doc_bytes[i])
                send_byte(doc_bytes[i], i == doc_bytes.size() - 1, next_gap(), 1'b0, '0);
        end
        byte_stream.valid <= 1'b0;

        wait_cycles = 0;
        while (expected_tokens.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);
        if (expected_tokens.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_tokens.size()));
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
